// ----- hdl/avcc_pse_pkg.sv -----
// types, phase and status codes shared by the avcC parameter-set extractor
package avcc_pse_pkg;

  localparam logic [15:0] MAX_RECORD_BYTES = 16'd65535;
  localparam logic [7:0]  AVCC_VERSION     = 8'd1;
  localparam int          QUEUE_DEPTH      = 4;
  localparam int          QUEUE_AW         = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_COUNT   = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_STOP    = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_VERSION  = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;
  localparam logic [1:0] ST_EARLY    = 2'd3;

  localparam logic KIND_COPY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pse_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [2:0]  length_size;
    logic [15:0] copied_count;
    logic [1:0]  status;
    logic        end_of_run;
  } pse_out_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] byte_position;
    logic [4:0]  entries_left;
    logic        run_index;
    logic [15:0] entry_bytes_left;
    logic [7:0]  length_high;
    logic [7:0]  held_profile;
    logic [7:0]  held_level;
    logic [2:0]  held_length_size;
    logic [15:0] copy_total;
    logic [1:0]  held_status;
  } pse_state_t;

endpackage

// ----- hdl/avcc_parameter_set_extractor_core.sv -----
// top level of the avcC parameter-set extractor
// Takes one record byte per in beat and accepts a new byte every clock cycle
// while in_stall is low; each byte is parsed in the cycle it is accepted and
// its result beats (none, one or two) land in a four-beat output queue. out
// beats leave one per cycle while out_stall is low, so a run of bytes that each
// make two beats (entry length pairs) drains at one beat per cycle. in_stall
// rises when fewer than two queue slots are free. Users must write record_size
// via the cfg port only while idle, unenforced by the block; cfg_ready is always high.
module avcc_parameter_set_extractor_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  avcc_pse_pkg::pse_in_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output avcc_pse_pkg::pse_out_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_data
);
  import avcc_pse_pkg::*;

  logic [15:0] record_size;
  pse_state_t  state;
  pse_state_t  state_next;
  logic [1:0]  beat_count;
  logic [1:0]  push_count;
  pse_out_t    beat0;
  pse_out_t    beat1;
  logic        room;
  logic        accept;

  assign cfg_ready  = 1'b1;
  assign in_stall   = !room;
  assign accept     = in_valid && room;
  assign push_count = accept ? beat_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_size <= '0;
      state <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        record_size <= cfg_data;
      end
      if (accept) begin
        state <= state_next;
      end
    end
  end

  avcc_pse_step u_step (
    .state       (state),
    .item        (in_data),
    .record_size (record_size),
    .state_next  (state_next),
    .beat_count  (beat_count),
    .beat0       (beat0),
    .beat1       (beat1)
  );

  avcc_pse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (beat0),
    .push1      (beat1),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- hdl/avcc_pse_step.sv -----
// per-byte parser step: next state and up to two result beats
module avcc_pse_step (
  input  avcc_pse_pkg::pse_state_t state,
  input  avcc_pse_pkg::pse_in_t    item,
  input  logic [15:0]              record_size,
  output avcc_pse_pkg::pse_state_t state_next,
  output logic [1:0]               beat_count,
  output avcc_pse_pkg::pse_out_t   beat0,
  output avcc_pse_pkg::pse_out_t   beat1
);
  import avcc_pse_pkg::*;

  function automatic pse_out_t copy_beat(input logic [7:0] b);
    pse_out_t r;
    r = '0;
    r.kind = KIND_COPY;
    r.out_byte = b;
    return r;
  endfunction

  function automatic pse_state_t end_run(input pse_state_t s);
    pse_state_t r;
    r = s;
    if (s.run_index == 1'b0) begin
      r.run_index = 1'b1;
      r.phase = PH_COUNT;
    end else begin
      r.phase = PH_DONE;
    end
    return r;
  endfunction

  function automatic pse_state_t finish_entry(input pse_state_t s);
    pse_state_t r;
    r = s;
    r.entries_left = s.entries_left - 5'd1;
    if (r.entries_left == 5'd0) begin
      r = end_run(r);
    end else begin
      r.phase = PH_LEN_HI;
    end
    return r;
  endfunction

  logic [15:0] limit;
  logic [15:0] pos;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] start;
  logic [17:0] entry_end;
  logic [1:0]  summary_status;
  pse_state_t  s;
  pse_out_t    summary;
  logic [1:0]  n;

  assign limit = (record_size < MAX_RECORD_BYTES) ? record_size : MAX_RECORD_BYTES;
  assign pos   = state.byte_position;
  assign b     = item.data_byte;
  assign len   = {state.length_high, b};
  assign start = pos - 16'd1;
  assign entry_end = {2'b00, start} + {2'b00, len} + 18'd2;

  always_comb begin
    s = state;
    n = 2'd0;
    beat0 = '0;
    beat1 = '0;
    summary = '0;
    summary_status = ST_OK;
    if (pos != 16'hffff) begin
      s.byte_position = pos + 16'd1;
    end
    if (pos < limit) begin
      unique case (state.phase)
        PH_HEADER: begin
          if (pos == 16'd0) begin
            if (b != AVCC_VERSION) begin
              s.held_status = ST_VERSION;
              s.phase = PH_STOP;
            end
          end else if (pos == 16'd1) begin
            s.held_profile = b;
          end else if (pos == 16'd3) begin
            s.held_level = b;
          end else if (pos == 16'd4) begin
            s.held_length_size = {1'b0, b[1:0]} + 3'd1;
            s.run_index = 1'b0;
            s.phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          s.entries_left = b[4:0];
          if (b[4:0] == 5'd0) begin
            s = end_run(s);
          end else begin
            s.phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          s.length_high = b;
          s.phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (entry_end > {2'b00, limit}) begin
            s.held_status = ST_OVERRUN;
            s.phase = PH_STOP;
          end else if (!item.last_byte) begin
            beat0 = copy_beat(state.length_high);
            beat1 = copy_beat(b);
            n = 2'd2;
            s.copy_total = state.copy_total + 16'd2;
            s.entry_bytes_left = len;
            if (len == 16'd0) begin
              s = finish_entry(s);
            end else begin
              s.phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          beat0 = copy_beat(b);
          n = 2'd1;
          s.copy_total = state.copy_total + 16'd1;
          s.entry_bytes_left = state.entry_bytes_left - 16'd1;
          if (s.entry_bytes_left == 16'd0) begin
            s = finish_entry(s);
          end
        end
        default: begin
        end
      endcase
    end

    if (item.last_byte) begin
      summary_status = s.held_status;
      if (s.held_status == ST_OK && s.phase != PH_DONE) begin
        summary_status = ST_EARLY;
      end
      summary.kind = KIND_SUMMARY;
      summary.profile = s.held_profile;
      summary.level = s.held_level;
      summary.length_size = s.held_length_size;
      summary.copied_count = s.copy_total;
      summary.status = summary_status;
      summary.end_of_run = 1'b1;
      if (n == 2'd0) begin
        beat0 = summary;
      end else begin
        beat1 = summary;
      end
      n = n + 2'd1;
      s = '0;
    end else begin
      if (n == 2'd1) begin
        beat0.end_of_run = 1'b1;
      end else if (n == 2'd2) begin
        beat1.end_of_run = 1'b1;
      end
    end

    state_next = s;
    beat_count = n;
  end

endmodule

// ----- hdl/avcc_pse_queue.sv -----
// result beat queue: up to two pushes per cycle, one pop
module avcc_pse_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             push_count,
  input  avcc_pse_pkg::pse_out_t push0,
  input  avcc_pse_pkg::pse_out_t push1,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output avcc_pse_pkg::pse_out_t out_data
);
  import avcc_pse_pkg::*;

  pse_out_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic [QUEUE_AW:0]     count_next;
  logic                  pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign room      = (count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign count_next = count + {{(QUEUE_AW - 1){1'b0}}, push_count}
                      - {{QUEUE_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + QUEUE_AW'(1)] <= push1;
    end
  end

endmodule

// ----- hdl/avcc_pse_checker.sv -----
// port-level assertions for the avcC parameter-set extractor, bound to the top level
module avcc_pse_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input avcc_pse_pkg::pse_out_t out_data,
  input logic                   cfg_ready
);
  import avcc_pse_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out beat changed while stalled");

  a_summary_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_SUMMARY |->
      out_data.end_of_run && out_data.out_byte == 8'd0 && out_data.length_size <= 3'd4)
    else $error("malformed summary beat");

  a_copy_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_COPY |->
      out_data.profile == 8'd0 && out_data.level == 8'd0 &&
      out_data.length_size == 3'd0 && out_data.copied_count == 16'd0 &&
      out_data.status == ST_OK)
    else $error("copy beat carries summary fields");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("cfg_ready dropped");

endmodule

bind avcc_parameter_set_extractor_core avcc_pse_checker u_avcc_pse_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

// ----- bench/testbench.sv -----
// self-checking testbench for the avcC parameter-set extractor core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import avcc_pse_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_BYTES    = 1250;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pse_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pse_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  pse_in_t     pending_bytes[$];
  pse_out_t    expected_beats[$];
  logic [15:0] size_writes[$];
  logic [7:0]  record_bytes[$];

  int send_idle_pct = 20;
  int recv_idle_pct = 20;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int size_writes_done = 0;
  int hold_offs_asked = 0;
  int hold_offs_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // parser state as the block should hold it
  logic [15:0] size_setting = '0;
  logic [2:0]  parse_phase;
  logic [15:0] parse_pos;
  logic [4:0]  entries_to_go;
  logic        in_pps;
  logic [16:0] entry_left;
  logic [7:0]  len_high;
  logic [7:0]  seen_profile;
  logic [7:0]  seen_level;
  logic [2:0]  seen_len_size;
  logic [15:0] bytes_copied;
  logic [1:0]  record_status;

  avcc_parameter_set_extractor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic clear_parse_state();
    parse_phase = PH_HEADER;
    parse_pos = '0;
    entries_to_go = '0;
    in_pps = 1'b0;
    entry_left = '0;
    len_high = '0;
    seen_profile = '0;
    seen_level = '0;
    seen_len_size = '0;
    bytes_copied = '0;
    record_status = ST_OK;
  endtask

  function automatic pse_out_t copy_beat(input logic [7:0] value);
    pse_out_t b;
    b = '0;
    b.kind = KIND_COPY;
    b.out_byte = value;
    return b;
  endfunction

  task automatic close_run();
    if (!in_pps) begin
      in_pps = 1'b1;
      parse_phase = PH_COUNT;
    end else begin
      parse_phase = PH_DONE;
    end
  endtask

  task automatic close_entry();
    entries_to_go = entries_to_go - 5'd1;
    if (entries_to_go == 0) close_run();
    else parse_phase = PH_LEN_HI;
  endtask

  // expected out beats for one accepted record byte
  task automatic parse_record_byte(input pse_in_t beat);
    pse_out_t   made[2];
    pse_out_t   summary;
    int         n;
    int         at;
    int         limit;
    int         entry_len;
    logic [1:0] st;
    n = 0;
    at = parse_pos;
    limit = (size_setting < MAX_RECORD_BYTES) ? size_setting : MAX_RECORD_BYTES;
    if (parse_pos != 16'hffff) parse_pos = parse_pos + 16'd1;
    if (at < limit) begin
      case (parse_phase)
        PH_HEADER: begin
          if (at == 0) begin
            if (beat.data_byte != AVCC_VERSION) begin
              record_status = ST_VERSION;
              parse_phase = PH_STOP;
            end
          end else if (at == 1) seen_profile = beat.data_byte;
          else if (at == 3) seen_level = beat.data_byte;
          else if (at == 4) begin
            seen_len_size = {1'b0, beat.data_byte[1:0]} + 3'd1;
            in_pps = 1'b0;
            parse_phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          entries_to_go = beat.data_byte[4:0];
          if (entries_to_go == 0) close_run();
          else parse_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_high = beat.data_byte;
          parse_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          entry_len = {len_high, beat.data_byte};
          // length bytes are held back until the whole entry is known to fit
          if (at - 1 + entry_len + 2 > limit) begin
            record_status = ST_OVERRUN;
            parse_phase = PH_STOP;
          end else if (!beat.last_byte) begin
            made[n] = copy_beat(len_high);
            n++;
            made[n] = copy_beat(beat.data_byte);
            n++;
            bytes_copied = bytes_copied + 16'd2;
            entry_left = 17'(entry_len);
            if (entry_len == 0) close_entry();
            else parse_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          made[n] = copy_beat(beat.data_byte);
          n++;
          bytes_copied = bytes_copied + 16'd1;
          entry_left = entry_left - 17'd1;
          if (entry_left == 0) close_entry();
        end
        default: ;
      endcase
    end
    if (beat.last_byte) begin
      st = record_status;
      if (st == ST_OK && parse_phase != PH_DONE) st = ST_EARLY;
      summary = '0;
      summary.kind = KIND_SUMMARY;
      summary.profile = seen_profile;
      summary.level = seen_level;
      summary.length_size = seen_len_size;
      summary.copied_count = bytes_copied;
      summary.status = st;
      made[n] = summary;
      n++;
      clear_parse_state();
    end
    for (int i = 0; i < n; i++) begin
      made[i].end_of_run = (i == n - 1);
      expected_beats.push_back(made[i]);
    end
  endtask

  task automatic field_mismatch(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    mismatches++;
  endtask

  task automatic check_beat(input pse_out_t want, input pse_out_t got);
    if (got.kind != want.kind) field_mismatch("kind", want.kind, got.kind);
    if (got.out_byte != want.out_byte) field_mismatch("out_byte", want.out_byte, got.out_byte);
    if (got.profile != want.profile) field_mismatch("profile", want.profile, got.profile);
    if (got.level != want.level) field_mismatch("level", want.level, got.level);
    if (got.length_size != want.length_size)
      field_mismatch("length_size", want.length_size, got.length_size);
    if (got.copied_count != want.copied_count)
      field_mismatch("copied_count", want.copied_count, got.copied_count);
    if (got.status != want.status) field_mismatch("status", want.status, got.status);
    if (got.end_of_run != want.end_of_run)
      field_mismatch("end_of_run", want.end_of_run, got.end_of_run);
  endtask

  // driver: one record byte per in beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_record_byte(in_data);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_offs_served != hold_offs_asked) begin
      hold_offs_served <= hold_offs_served + 1;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: out beat with none expected, actual %h", $time, out_data);
        mismatches++;
      end else begin
        check_beat(expected_beats.pop_front(), out_data);
      end
    end
  end

  // record_size writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      size_setting = cfg_data;
      size_writes_done++;
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && size_writes.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_data <= size_writes.pop_front();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("avcc_parameter_set_extractor_core test failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_taken != bytes_queued || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_record_size(input logic [15:0] value);
    int target;
    target = size_writes_done + 1;
    size_writes.push_back(value);
    while (size_writes_done != target) @(posedge clk);
  endtask

  task automatic send_record(input int n_bytes);
    pse_in_t beat;
    for (int i = 0; i < n_bytes; i++) begin
      beat.data_byte = record_bytes[i];
      beat.last_byte = (i == n_bytes - 1);
      pending_bytes.push_back(beat);
      bytes_queued++;
    end
  endtask

  task automatic add_entries(input int count, input int max_len);
    int len;
    for (int i = 0; i < count; i++) begin
      len = $urandom_range(max_len);
      record_bytes.push_back(len[15:8]);
      record_bytes.push_back(len[7:0]);
      repeat (len) record_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // mostly well-formed records with random content, some pure noise
  task automatic build_record();
    int         entry_count;
    int         max_len;
    logic [7:0] count_byte;
    record_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) record_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) record_bytes[0] = AVCC_VERSION;
    end else begin
      record_bytes.push_back(AVCC_VERSION);
      repeat (4) record_bytes.push_back(8'($urandom_range(255)));
      for (int run = 0; run < 2; run++) begin
        entry_count = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(3);
        max_len = (entry_count > 3) ? 1 : (($urandom_range(19) == 0) ? 300 : 6);
        count_byte = 8'($urandom_range(7) * 32 + entry_count);
        record_bytes.push_back(count_byte);
        add_entries(entry_count, max_len);
      end
      repeat ($urandom_range(2)) record_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int n;
    int cut;
    int phase_no;
    int random_start;
    clear_parse_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // bad version byte
    write_record_size(16'd16);
    record_bytes = '{8'h00, 8'hff};
    send_record(record_bytes.size());
    wait_idle();
    // complete record, field extremes, count with upper bits set
    write_record_size(16'd10);
    record_bytes = '{8'h01, 8'hff, 8'h00, 8'hff, 8'hff, 8'he1, 8'h00, 8'h01, 8'haa, 8'h00};
    send_record(record_bytes.size());
    wait_idle();
    // entry overruns the record size, byte past it ignored
    write_record_size(16'd9);
    record_bytes = '{8'h01, 8'h42, 8'hc0, 8'h1e, 8'hfd, 8'h01, 8'h00, 8'h05, 8'h7f};
    send_record(record_bytes.size());
    wait_idle();
    // record ends on a length low byte
    write_record_size(16'd12);
    record_bytes = '{8'h01, 8'h4d, 8'h00, 8'h28, 8'hfe, 8'h02, 8'h00, 8'h03};
    send_record(record_bytes.size());
    wait_idle();
    // zero size, every byte ignored
    write_record_size(16'd0);
    record_bytes = '{8'h01};
    send_record(1);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    write_record_size(16'hffff);
    repeat (4) begin
      build_record();
      send_record(record_bytes.size());
    end
    hold_offs_asked++;
    wait_idle();
    send_idle_pct = 20;

    random_start = bytes_queued;
    phase_no = 0;
    while (bytes_queued - random_start < RANDOM_BYTES) begin
      send_idle_pct = (phase_no >= 12 && phase_no < 24) ? 0 : 20;
      recv_idle_pct = send_idle_pct;
      if ($urandom_range(9) < 6) begin
        build_record();
        n = record_bytes.size();
        cut = ($urandom_range(6) == 0) ? $urandom_range(1, n) : n;
        write_record_size(16'(($urandom_range(4) == 0) ? $urandom_range(n) : n));
        send_record(cut);
      end else begin
        write_record_size(16'($urandom_range(1) ? 16'hffff : $urandom_range(200, 65534)));
        repeat ($urandom_range(1, 5)) begin
          build_record();
          send_record(record_bytes.size());
        end
      end
      wait_idle();
      phase_no++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("avcc_parameter_set_extractor_core test passed");
    end else begin
      $display("avcc_parameter_set_extractor_core test failed");
    end
    $finish;
  end

endmodule
